// File: rtl/bpra_pkg.sv
`timescale 1ns / 1ps

package bpra_pkg;

    // Bitmap geometry: one 32-bit word covers 32 pages.
    localparam int WORD_BITS      = 32;
    localparam int BIT_IDX_W      = 5;

    // Defaults and fixed limits of the allocator.
    localparam int POOL_PAGES_DEF = 4096;
    localparam int MAX_RUN        = 64;

    // Field widths.
    localparam int CFG_W          = 13;
    localparam int COUNT_W        = 7;
    localparam int PAGE_IN_W      = 12;
    localparam int PAGE_OUT_W     = 12;

    // Configuration port.
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;
    localparam int REG_SEL_BIT    = 2;

    localparam logic [CFG_W-1:0]     TOTAL_RESET    = 13'd4096;
    localparam logic [CFG_W-1:0]     RESERVED_RESET = 13'd1;
    localparam logic [WORD_BITS-1:0] WORD_ONES      = '1;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_NO_SPACE     = 2'd1,
        STAT_OUT_OF_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        REG_TOTAL    = 1'b0,
        REG_RESERVED = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_func                 func;
        logic [COUNT_W-1:0]    page_count;
        logic [PAGE_IN_W-1:0]  first_page;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [PAGE_OUT_W-1:0] start_page;
    } t_rsp;

    typedef struct packed {
        logic [CFG_W-1:0] total_pages;
        logic [CFG_W-1:0] reserved_pages;
    } t_cfg;

    typedef struct packed {
        logic                 found;
        logic [BIT_IDX_W-1:0] pos;
        logic [COUNT_W-1:0]   carry;
    } t_scan_res;

endpackage

// File: rtl/bitmap_page_run_allocator_core.sv
`timescale 1ns / 1ps
// Allocate: the scan pipeline fills, then one bitmap word is scanned per cycle from the word
// holding reserved_pages up to the word that completes the run; each word of the run is then
// read and written back, and the result is loaded into the output register.
// Free: each word touched is read and written back; a rejected request goes to the response.
// One request at a time, paced by the single-word scan unit and the bitmap read-modify-write.
// Reset is synchronous, active low; a clearing pass then sets every word.

module bitmap_page_run_allocator_core #(
    parameter int POOL_PAGES = bpra_pkg::POOL_PAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bpra_pkg::t_req                      i_in_word,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bpra_pkg::t_rsp                      o_out_word,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpra_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bpra_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bpra_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import bpra_pkg::*;

    // Bitmap words, page index width and the width used to compare page
    // counts against the configuration registers.
    localparam int POOL_WORDS = POOL_PAGES / WORD_BITS;
    localparam int POOL_LIMIT = POOL_WORDS * WORD_BITS;
    localparam int AW         = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
    localparam int PGW        = AW + BIT_IDX_W;
    localparam int LW         = (PGW + 1 > CFG_W) ? PGW + 1 : CFG_W;
    localparam int XW         = LW - BIT_IDX_W;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_RMW_RD,
        S_RMW_WR,
        S_RESP
    } t_state;

    t_state               r_state;
    t_func                r_func;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   r_run;
    logic [AW:0]          r_iss;
    logic                 r_v1, r_v2;
    logic [AW-1:0]        r_idx1, r_idx2;
    logic [PGW-1:0]       r_s, r_e;
    logic [AW-1:0]        r_cur;
    t_status              r_status;
    logic [PAGE_OUT_W-1:0] r_start;
    logic                 r_out_valid;
    t_rsp                 r_out_word;

    t_cfg                 w_cfg;
    logic [LW-1:0]        w_tot, w_lim_raw, w_lim, w_res, w_fsum;
    logic [XW-1:0]        w_lim_words, w_res_word;
    logic                 w_alloc_reject, w_last;

    logic                 w_we;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [WORD_BITS-1:0] w_wdata, w_rdata, w_scan_mask, w_scan_word, w_mask;
    logic [BIT_IDX_W-1:0] w_lo, w_hi;
    t_scan_res            w_scan;
    logic [PGW-1:0]       w_run_end, w_run_start, w_free_s, w_free_e;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    bpra_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The managed range is clipped to the pool and rounded down to whole
    // words, so the scan never needs an upper mask inside a word.
    assign w_tot       = LW'(w_cfg.total_pages);
    assign w_lim_raw   = (w_tot > LW'(POOL_LIMIT)) ? LW'(POOL_LIMIT) : w_tot;
    assign w_lim       = {w_lim_raw[LW-1:BIT_IDX_W], BIT_IDX_W'(0)};
    assign w_lim_words = w_lim[LW-1:BIT_IDX_W];
    assign w_res       = LW'(w_cfg.reserved_pages);
    assign w_res_word  = w_res[LW-1:BIT_IDX_W];

    // A zero or oversize count, or a reserved area that covers the whole
    // managed range, can never be satisfied.
    assign w_alloc_reject = (i_in_word.page_count == '0)
                         || (int'(i_in_word.page_count) > MAX_RUN)
                         || (w_res >= w_lim);

    // The free range is checked against the managed range in full width.
    assign w_fsum   = LW'(i_in_word.first_page) + LW'(i_in_word.page_count);
    assign w_free_s = PGW'(i_in_word.first_page);
    assign w_free_e = PGW'(w_fsum - LW'(1));

    // ------------------------------------------------------------------
    // Free bitmap, one bit per page, 1 = free.
    // ------------------------------------------------------------------
    bpra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (POOL_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Scan unit. The word read in the previous cycle enters it with the pages
    // below reserved_pages masked off. It has one register stage inside;
    // its result for a word is seen when r_v2 is set, together with the run
    // carried over from the word before.
    // ------------------------------------------------------------------
    assign w_scan_mask = (XW'(r_idx1) == w_res_word) ? (WORD_ONES << w_res[BIT_IDX_W-1:0])
                       : WORD_ONES;
    assign w_scan_word = w_rdata & w_scan_mask;

    bpra_scan u_scan (
        .i_clk   (i_clk),
        .i_word  (w_scan_word),
        .i_count (r_count),
        .i_run   (r_run),
        .o_res   (w_scan)
    );

    assign w_run_end   = {r_idx2, w_scan.pos};
    assign w_run_start = w_run_end + PGW'(1) - PGW'(r_count);
    assign w_last      = (XW'(r_idx2) + XW'(1)) == w_lim_words;

    // Bits of the current word that fall in the run being marked.
    assign w_lo   = (r_cur == r_s[PGW-1:BIT_IDX_W]) ? r_s[BIT_IDX_W-1:0] : '0;
    assign w_hi   = (r_cur == r_e[PGW-1:BIT_IDX_W]) ? r_e[BIT_IDX_W-1:0]
                  : BIT_IDX_W'(WORD_BITS - 1);
    assign w_mask = (WORD_ONES << w_lo) & (WORD_ONES >> (BIT_IDX_W'(WORD_BITS - 1) - w_hi));

    // Bitmap port control: the clearing pass and the read-modify-write of a
    // run write, the scan and the read-modify-write read.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wdata = w_rdata;
        w_raddr = r_cur;
        case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_iss[AW-1:0];
                w_wdata = WORD_ONES;
            end
            S_SCAN: begin
                w_raddr = r_iss[AW-1:0];
            end
            S_RMW_WR: begin
                w_we    = 1'b1;
                w_wdata = (r_func == FUNC_FREE) ? (w_rdata | w_mask) : (w_rdata & ~w_mask);
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer. One request is taken in the idle state and carried through
    // scan, bitmap update and response before the next one is accepted.
    // The output register holds a finished word until the consumer takes it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_iss       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In the response state a taken word is replaced by the new one below.
            if (r_out_valid && i_out_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    if (r_iss[AW-1:0] == AW'(POOL_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_iss <= r_iss + (AW + 1)'(1);
                    end
                end

                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_in_word.func;
                        r_count <= i_in_word.page_count;
                        r_start <= '0;
                        r_run   <= '0;
                        r_v1    <= 1'b0;
                        r_v2    <= 1'b0;
                        if (i_in_word.func == FUNC_ALLOC) begin
                            if (w_alloc_reject) begin
                                r_status <= STAT_NO_SPACE;
                                r_state  <= S_RESP;
                            end else begin
                                // The search starts at the word holding the
                                // first page that may be granted.
                                r_iss   <= (AW + 1)'(w_res_word);
                                r_state <= S_SCAN;
                            end
                        end else begin
                            if (w_fsum > w_lim) begin
                                r_status <= STAT_OUT_OF_RANGE;
                                r_state  <= S_RESP;
                            end else if (i_in_word.page_count == '0) begin
                                r_status <= STAT_OK;
                                r_state  <= S_RESP;
                            end else begin
                                r_status <= STAT_OK;
                                r_s      <= w_free_s;
                                r_e      <= w_free_e;
                                r_cur    <= w_free_s[PGW-1:BIT_IDX_W];
                                r_state  <= S_RMW_RD;
                            end
                        end
                    end
                end

                S_SCAN: begin
                    // Issue one word read per cycle until the range ends.
                    if (XW'(r_iss) < w_lim_words) begin
                        r_iss <= r_iss + (AW + 1)'(1);
                        r_v1  <= 1'b1;
                    end else begin
                        r_v1 <= 1'b0;
                    end
                    r_idx1 <= r_iss[AW-1:0];
                    r_v2   <= r_v1;
                    r_idx2 <= r_idx1;

                    if (r_v2) begin
                        if (w_scan.found) begin
                            // Reads still in flight are dropped.
                            r_s      <= w_run_start;
                            r_e      <= w_run_end;
                            r_cur    <= w_run_start[PGW-1:BIT_IDX_W];
                            r_status <= STAT_OK;
                            r_start  <= PAGE_OUT_W'(w_run_start);
                            r_state  <= S_RMW_RD;
                        end else if (w_last) begin
                            r_status <= STAT_NO_SPACE;
                            r_state  <= S_RESP;
                        end else begin
                            r_run <= w_scan.carry;
                        end
                    end
                end

                S_RMW_RD: begin
                    r_state <= S_RMW_WR;
                end

                S_RMW_WR: begin
                    if (r_cur == r_e[PGW-1:BIT_IDX_W]) begin
                        r_state <= S_RESP;
                    end else begin
                        r_cur   <= r_cur + AW'(1);
                        r_state <= S_RMW_RD;
                    end
                end

                S_RESP: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid           <= 1'b1;
                        r_out_word.status     <= r_status;
                        r_out_word.start_page <= r_start;
                        r_state               <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: rtl/bpra_ram.sv
`timescale 1ns / 1ps

module bpra_ram #(
    parameter  int WIDTH  = bpra_pkg::WORD_BITS,
    parameter  int DEPTH  = bpra_pkg::POOL_PAGES_DEF / bpra_pkg::WORD_BITS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bpra_cfg.sv
`timescale 1ns / 1ps

module bpra_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpra_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bpra_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bpra_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output bpra_pkg::t_cfg                      o_cfg
);

    import bpra_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    // Registers sit on 4-byte boundaries, so one address bit picks the register.
    assign w_idx  = t_reg_idx'(paddr[REG_SEL_BIT]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_pages    <= TOTAL_RESET;
            r_cfg.reserved_pages <= RESERVED_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_TOTAL:    r_cfg.total_pages    <= pwdata[CFG_W-1:0];
                REG_RESERVED: r_cfg.reserved_pages <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TOTAL:    prdata = APB_DATA_W'(r_cfg.total_pages);
            REG_RESERVED: prdata = APB_DATA_W'(r_cfg.reserved_pages);
            default:      prdata = '0;
        endcase
    end

endmodule

// File: rtl/bpra_scan.sv
`timescale 1ns / 1ps

module bpra_scan (
    input  logic                              i_clk,
    input  logic [bpra_pkg::WORD_BITS-1:0]    i_word,
    input  logic [bpra_pkg::COUNT_W-1:0]      i_count,
    input  logic [bpra_pkg::COUNT_W-1:0]      i_run,
    output bpra_pkg::t_scan_res               o_res
);

    import bpra_pkg::*;

    logic [WORD_BITS-1:0] w_p1, w_p2, w_p4, w_p8, w_p16, w_p32;
    logic [WORD_BITS-1:0] w_ph, w_q, w_t;
    logic [BIT_IDX_W-1:0] w_d, w_lead;
    logic                 w_long;

    logic [WORD_BITS-1:0] r_q, r_t;
    logic                 r_all;
    logic [BIT_IDX_W-1:0] r_lead;

    logic [COUNT_W:0]     w_k;
    logic [WORD_BITS-1:0] w_gate, w_cand;
    logic [BIT_IDX_W-1:0] w_pos;

    // First half, independent of the incoming run: bit i of w_pN is set when
    // the N pages ending at bit i are all free inside this word.
    assign w_p1   = i_word;
    assign w_p2   = w_p1 & (w_p1 << 1);
    assign w_p4   = w_p2 & (w_p2 << 2);
    assign w_p8   = w_p4 & (w_p4 << 4);
    assign w_p16  = w_p8 & (w_p8 << 8);
    assign w_p32  = w_p16 & (w_p16 << 16);
    assign w_long = (i_count > COUNT_W'(WORD_BITS));

    // A run of length c is two overlapping runs of h, the largest power of two
    // not above c, offset by c - h.
    always_comb begin
        if (i_count[5]) begin
            w_ph = w_p32;
            w_d  = '0;
        end else if (i_count[4]) begin
            w_ph = w_p16;
            w_d  = {1'b0, i_count[3:0]};
        end else if (i_count[3]) begin
            w_ph = w_p8;
            w_d  = {2'b0, i_count[2:0]};
        end else if (i_count[2]) begin
            w_ph = w_p4;
            w_d  = {3'b0, i_count[1:0]};
        end else if (i_count[1]) begin
            w_ph = w_p2;
            w_d  = {4'b0, i_count[0]};
        end else begin
            w_ph = w_p1;
            w_d  = '0;
        end
    end

    assign w_q = w_long ? '0 : (w_ph & (w_ph << w_d));

    // Pages from bit 0 up to bit i all free: the run from the previous word
    // continues through them.
    assign w_t = (~i_word & (i_word + WORD_BITS'(1))) - WORD_BITS'(1);

    // Length of the free run touching the top of the word.
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (!i_word[i]) begin
                w_lead = BIT_IDX_W'(WORD_BITS - 1 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q    <= w_q;
        r_t    <= w_t;
        r_all  <= &i_word;
        r_lead <= w_lead;
    end

    // Second half: join the carried run and pick the lowest end position.
    assign w_k    = {1'b0, i_count} - {1'b0, i_run} - (COUNT_W + 1)'(1);
    assign w_gate = (w_k >= (COUNT_W + 1)'(WORD_BITS)) ? '0
                  : (WORD_ONES << w_k[BIT_IDX_W-1:0]);
    assign w_cand = r_q | (r_t & w_gate);

    always_comb begin
        w_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w_cand[i]) begin
                w_pos = BIT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_res.found = |w_cand;
        o_res.pos   = w_pos;
        o_res.carry = r_all ? (i_run + COUNT_W'(WORD_BITS)) : COUNT_W'(r_lead);
    end

endmodule

// File: rtl/bpra_checker.sv
`timescale 1ns / 1ps

module bpra_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input bpra_pkg::t_req                   i_in_word,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input bpra_pkg::t_rsp                   o_out_word
);

    import bpra_pkg::*;

    // The bitmap is being cleared right after reset, so no word is taken.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready high right after reset");

    // Only one request is in flight at a time.
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready high in the cycle after an accepted word");

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed or dropped while stalled");

    // Only a successful allocate reports a start page.
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != STAT_OK)) |-> (o_out_word.start_page == '0))
        else $error("nonzero start page on a failed request");

endmodule

bind bitmap_page_run_allocator_core bpra_checker u_bpra_checker (.*);

// File: verif/bitmap_page_run_allocator_core_test.sv
`timescale 1ns / 1ps

module bitmap_page_run_allocator_core_test;

    import bpra_pkg::*;

    // Bitmap geometry seen by the testbench. The pool is the default build of the block.
    localparam int POOL_WORDS   = POOL_PAGES_DEF / WORD_BITS;
    localparam int POOL_LIMIT   = POOL_WORDS * WORD_BITS;

    // Every request produces exactly one result, so a short settle after the last
    // result is enough before a register write touches the block.
    localparam int DRAIN_CYCLES = 8;
    // Long receiver hold that backs the block up, well beyond one worst-case allocate.
    localparam int LONG_HOLD    = 400;
    // Random requests per register setting.
    localparam int PHASE_ITEMS  = 125;

    // One outstanding grant that the stimulus may later hand back.
    typedef struct {
        int first;
        int count;
    } t_run;

    // Scoreboard: keeps its own copy of the free bitmap and the two registers,
    // predicts the result word of every accepted request, and checks results in order.
    class alloc_scoreboard;
        logic [WORD_BITS-1:0] free_map [POOL_WORDS];
        logic [CFG_W-1:0]     total_reg;
        logic [CFG_W-1:0]     reserved_reg;
        t_rsp                 expected_q [$];
        int                   mismatches;
        int                   requests;
        int                   grants;
        int                   no_space_cnt;
        int                   range_rejects;
        int                   frees_done;

        function new();
            foreach (free_map[w]) free_map[w] = WORD_ONES;
            total_reg      = TOTAL_RESET;
            reserved_reg   = RESERVED_RESET;
            mismatches     = 0;
            requests       = 0;
            grants         = 0;
            no_space_cnt   = 0;
            range_rejects  = 0;
            frees_done     = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_W-1:0] value);
            if (idx == REG_TOTAL) begin
                total_reg = value;
            end else begin
                reserved_reg = value;
            end
        endfunction

        function logic [CFG_W-1:0] reg_value(t_reg_idx idx);
            return (idx == REG_TOTAL) ? total_reg : reserved_reg;
        endfunction

        // Pages actually managed: clamped to the pool and rounded down to whole words.
        function int managed_pages();
            int t;
            t = total_reg;
            if (t > POOL_LIMIT) t = POOL_LIMIT;
            return (t / WORD_BITS) * WORD_BITS;
        endfunction

        function t_rsp note_request(t_req req);
            t_rsp rsp;
            int   lim;
            int   count;
            int   first;
            int   run;
            int   p;
            int   q;
            lim             = managed_pages();
            count           = req.page_count;
            first           = req.first_page;
            rsp.status      = STAT_NO_SPACE;
            rsp.start_page  = '0;
            if (req.func == FUNC_ALLOC) begin
                if (count != 0 && count <= MAX_RUN) begin
                    // First fit from the reserved boundary, runs counted across words.
                    run = 0;
                    for (p = reserved_reg; p < lim; p++) begin
                        if (free_map[p / WORD_BITS][p % WORD_BITS]) begin
                            run++;
                            if (run == count) begin
                                for (q = p + 1 - count; q <= p; q++) begin
                                    free_map[q / WORD_BITS][q % WORD_BITS] = 1'b0;
                                end
                                rsp.status     = STAT_OK;
                                rsp.start_page = PAGE_OUT_W'(p + 1 - count);
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
            end else if (first + count > lim) begin
                rsp.status = STAT_OUT_OF_RANGE;
            end else begin
                for (p = first; p < first + count; p++) begin
                    free_map[p / WORD_BITS][p % WORD_BITS] = 1'b1;
                end
                rsp.status = STAT_OK;
            end
            requests++;
            if (rsp.status == STAT_OUT_OF_RANGE) range_rejects++;
            else if (rsp.status == STAT_NO_SPACE) no_space_cnt++;
            else if (req.func == FUNC_ALLOC) grants++;
            else frees_done++;
            expected_q.push_back(rsp);
            return rsp;
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                $error("result word with nothing outstanding: status %0d start_page %0d",
                       got.status, got.start_page);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.start_page !== want.start_page) begin
                $error("start_page: expected %0d, actual %0d", want.start_page, got.start_page);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // All block inputs start at known values.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_req                  i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_rsp                  o_out_word;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    alloc_scoreboard sb = new();

    // Runs granted so far and not yet handed back by the stimulus.
    t_run granted_runs [$];
    // Sender state: whether valid is up, and how many more words go back to back.
    bit   in_up        = 1'b0;
    int   burst_left   = 0;
    // The main flow bumps this to ask the receiver for one long hold.
    int   hold_asks    = 0;
    int   settings_cnt = 0;

    bitmap_page_run_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every result word accepted at a rising edge is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_word);
        end
    end

    // Receiver pacing. It runs on its own: stretches of steady ready, random ready,
    // sparse ready and full stall, plus a long counted hold whenever the main flow asks.
    initial begin : rx_pacing
        int mode;
        int span;
        int seen;
        seen = 0;
        forever begin
            if (hold_asks != seen) begin
                seen = hold_asks;
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 48);
                repeat (span) begin
                    @(negedge i_clk);
                    case (mode)
                        0: begin
                            i_out_ready <= 1'b1;
                        end
                        1: begin
                            i_out_ready <= 1'($urandom_range(0, 1));
                        end
                        2: begin
                            i_out_ready <= ($urandom_range(0, 3) == 0);
                        end
                        default: begin
                            i_out_ready <= 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // Lower valid once, only if it is up, so no step sees two writes to it.
    task automatic drop_valid();
        if (in_up) begin
            i_in_valid <= 1'b0;
            in_up = 1'b0;
        end
    endtask

    // Sender bursts: a run of back-to-back words, then a random gap with valid low.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                drop_valid();
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // Offer one request word; called at a falling edge, returns at a falling edge.
    // The prediction is made at the edge that accepts the word, and granted runs are
    // remembered so that later frees can hand them back.
    task automatic offer(t_req req);
        t_rsp pred;
        if (!in_up) i_in_valid <= 1'b1;
        in_up = 1'b1;
        i_in_word <= req;
        do @(posedge i_clk); while (!o_in_ready);
        pred = sb.note_request(req);
        if (req.func == FUNC_ALLOC && pred.status == STAT_OK) begin
            granted_runs.push_back('{first: int'(pred.start_page), count: int'(req.page_count)});
        end
        @(negedge i_clk);
        pace();
    endtask

    function automatic t_req mk_alloc(int count, int first = 0);
        t_req r;
        r.func       = FUNC_ALLOC;
        r.page_count = COUNT_W'(count);
        r.first_page = PAGE_IN_W'(first);
        return r;
    endfunction

    function automatic t_req mk_free(int first, int count);
        t_req r;
        r.func       = FUNC_FREE;
        r.page_count = COUNT_W'(count);
        r.first_page = PAGE_IN_W'(first);
        return r;
    endfunction

    // Random request. Most traffic is well formed: allocates of legal sizes and frees of
    // runs that were actually granted. The rest is noise: random frees, zero and
    // oversized allocates.
    function automatic t_req pick_request();
        t_req r;
        int   sel;
        int   k;
        int   size_sel;
        r.first_page = PAGE_IN_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 32 && granted_runs.size() > 0) begin
            k            = $urandom_range(0, granted_runs.size() - 1);
            r.func       = FUNC_FREE;
            r.first_page = PAGE_IN_W'(granted_runs[k].first);
            r.page_count = COUNT_W'(granted_runs[k].count);
            granted_runs.delete(k);
        end else if (sel < 45) begin
            r.func = FUNC_FREE;
            if (sel < 40) begin
                r.first_page = PAGE_IN_W'($urandom_range(0, sb.managed_pages()));
                r.page_count = COUNT_W'($urandom_range(0, 16));
            end else begin
                r.page_count = COUNT_W'($urandom_range(0, 127));
            end
        end else begin
            r.func   = FUNC_ALLOC;
            size_sel = $urandom_range(0, 99);
            if (size_sel < 55) r.page_count = COUNT_W'($urandom_range(1, 8));
            else if (size_sel < 77) r.page_count = COUNT_W'($urandom_range(9, 32));
            else if (size_sel < 90) r.page_count = COUNT_W'($urandom_range(33, MAX_RUN));
            else if (size_sel < 95) r.page_count = '0;
            else r.page_count = COUNT_W'($urandom_range(MAX_RUN + 1, 127));
        end
        return r;
    endfunction

    // APB write: setup cycle, then access until pready; the register takes the value
    // at the access edge, which is where the scoreboard copy is updated as well.
    task automatic reg_write(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(idx) << REG_SEL_BIT);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value[CFG_W-1:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // APB read of one register, compared with what was last written.
    task automatic reg_readback(t_reg_idx idx);
        logic [APB_DATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(int'(idx) << REG_SEL_BIT);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[CFG_W-1:0] !== sb.reg_value(idx)) begin
            $error("%s: expected %0d, actual %0d", idx.name(), sb.reg_value(idx),
                   got[CFG_W-1:0]);
            sb.mismatches++;
        end
    endtask

    // New register setting. The block must be idle: valid goes low, every predicted
    // result is collected, and a few cycles pass before the port is touched. The upper
    // bits of the write data are random since only the low bits are kept.
    task automatic set_config(int total, int reserved);
        drop_valid();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        reg_write(REG_TOTAL, {(APB_DATA_W - CFG_W)'($urandom), CFG_W'(total)});
        reg_write(REG_RESERVED, {(APB_DATA_W - CFG_W)'($urandom), CFG_W'(reserved)});
        reg_readback(REG_TOTAL);
        reg_readback(REG_RESERVED);
        settings_cnt++;
    endtask

    initial begin : main_flow
        int total;
        // Reset is held at the start; the block then clears its bitmap on its own,
        // which the first request simply waits out through o_in_ready.
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset setting: zero and oversized allocates, a grant
        // right above the reserved page, runs that straddle word boundaries, a free of
        // zero length, a free of pages that are already free, frees at and past the
        // top of the pool, and a free of the reserved page that must not make it
        // grantable.
        offer(mk_alloc(0));
        offer(mk_alloc(MAX_RUN + 1));
        offer(mk_alloc(127, POOL_LIMIT - 1));
        offer(mk_alloc(1));
        offer(mk_alloc(31));
        offer(mk_alloc(MAX_RUN));
        offer(mk_free(0, 0));
        offer(mk_free(4000, 10));
        offer(mk_free(POOL_LIMIT - 1, 1));
        offer(mk_free(POOL_LIMIT - 1, 2));
        offer(mk_free(0, 1));
        offer(mk_alloc(1));
        offer(mk_free(2, 31));
        offer(mk_alloc(32));
        offer(mk_alloc(31));

        // Nothing managed: every allocate fails and any nonempty free is out of range.
        set_config(0, 0);
        offer(mk_alloc(1));
        offer(mk_free(0, 0));
        offer(mk_free(0, 1));

        // Both registers at their top value: the range clamps to the pool, while the
        // reserved boundary sits past it, so nothing can be granted.
        set_config(8191, 8191);
        offer(mk_alloc(1));
        offer(mk_free(POOL_LIMIT - MAX_RUN, MAX_RUN));

        // Only the last word is grantable.
        set_config(POOL_LIMIT, POOL_LIMIT - WORD_BITS);
        offer(mk_alloc(WORD_BITS + 1));
        offer(mk_alloc(WORD_BITS));
        offer(mk_alloc(1));

        // A range that rounds down to 96 pages with the reserved boundary right at it.
        set_config(100, 96);
        offer(mk_alloc(1));
        offer(mk_free(90, 6));
        offer(mk_free(90, 7));

        // Random part over several settings. The receiver is asked for a long hold at
        // the start of some phases, so the block backs up and stalls its input while
        // the sender keeps offering words.
        set_config(POOL_LIMIT, 1);
        hold_asks++;
        repeat (PHASE_ITEMS) offer(pick_request());

        // Small pool: it fills quickly, so failures and reuse of freed runs dominate.
        set_config(640, 37);
        repeat (PHASE_ITEMS) offer(pick_request());

        // Oversized total with nothing reserved, after a shrink that left bits behind.
        set_config(8191, 0);
        hold_asks++;
        repeat (PHASE_ITEMS) offer(pick_request());

        set_config(100, 0);
        repeat (PHASE_ITEMS) offer(pick_request());

        total = $urandom_range(0, 8191);
        set_config(total, $urandom_range(0, total / 2));
        hold_asks++;
        repeat (PHASE_ITEMS) offer(pick_request());

        // Collect everything still outstanding, then give the block time to show any
        // stray result word before the verdict.
        drop_valid();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4 * DRAIN_CYCLES) @(negedge i_clk);

        $display("Ran %0d requests over %0d register settings: %0d runs granted,",
                 sb.requests, settings_cnt + 1, sb.grants);
        $display("%0d allocates refused, %0d frees done, %0d frees out of range.",
                 sb.no_space_cnt, sb.frees_done, sb.range_rejects);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: a correct run finishes long before it fires, even with every allocate
    // scanning the whole bitmap and every result waiting out the longest stall.
    initial begin : watchdog
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
